FILE: rtl/core/shm_pkg.sv
// ----------------------------------------------------------------------------
// shm_pkg: shared types and constants for the short-path string hash core
// Hash constants, datapath operation codes, and the command/status structs
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package shm_pkg;

  localparam logic [31:0] HASH_SEED = 32'h9747b28c;
  localparam logic [31:0] MIX_C1    = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2    = 32'h1b873593;
  localparam logic [31:0] MIX_C3    = 32'he6546b64;
  localparam logic [31:0] FIN_C1    = 32'h85ebca6b;
  localparam logic [31:0] FIN_C2    = 32'hc2b2ae35;

  // datapath operations, one per cycle
  localparam logic [3:0] OP_NOP   = 4'd0;
  localparam logic [3:0] OP_SC1   = 4'd1;  // t = src * C1
  localparam logic [3:0] OP_SC2   = 4'd2;  // t = rotl(t,15) * C2
  localparam logic [3:0] OP_BODY  = 4'd3;  // h = rotl(h^t,13) * 5 + C3
  localparam logic [3:0] OP_TAIL  = 4'd4;  // h = h ^ t
  localparam logic [3:0] OP_FMIX1 = 4'd5;  // h = fold16(h ^ len) * FIN_C1
  localparam logic [3:0] OP_FMIX2 = 4'd6;  // h = fold13(h) * FIN_C2
  localparam logic [3:0] OP_QPRE  = 4'd7;  // h = quick-path premix
  localparam logic [3:0] OP_QMUL  = 4'd8;  // h = h * FIN_C1
  localparam logic [3:0] OP_OUT   = 4'd9;  // result = fold16(h), or 1 if that is zero; h = seed

  // operand source for OP_SC1 / first word for OP_QPRE
  localparam logic [1:0] SRC_W0 = 2'd0;
  localparam logic [1:0] SRC_W1 = 2'd1;
  localparam logic [1:0] SRC_K  = 2'd2;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] src;
    logic       accept;
    logic       early_wr;
    logic       early_idx;
  } cmd_t;

  typedef struct packed {
    logic is_last;
    logic is_full;
  } stat_t;

endpackage

FILE: rtl/core/shm_ctrl.sv
// ----------------------------------------------------------------------------
// shm_ctrl: sequencer for the short-path string hash core
// Tracks held early words, picks quick or long path, and steps the datapath
// through scramble, body, finalizer and output operations.
// ----------------------------------------------------------------------------
module shm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  shm_pkg::stat_t       stat,
  output shm_pkg::cmd_t        cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SC1  = 4'd1;
  localparam logic [3:0] S_SC2  = 4'd2;
  localparam logic [3:0] S_MIX  = 4'd3;
  localparam logic [3:0] S_FM1  = 4'd4;
  localparam logic [3:0] S_FM2  = 4'd5;
  localparam logic [3:0] S_QPRE = 4'd6;
  localparam logic [3:0] S_QMUL = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0] state, state_next;
  logic [1:0] cnt, cnt_next;
  logic [1:0] src, src_next;
  logic       lastf, lastf_next;
  logic       fullf, fullf_next;
  logic       out_valid_next;
  logic       issue_out;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    src_next   = src;
    lastf_next = lastf;
    fullf_next = fullf;
    issue_out  = 1'b0;
    cmd        = '0;
    cmd.op     = shm_pkg::OP_NOP;
    cmd.src    = src;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (stat.is_last && cnt[1] == 1'b0) begin
            src_next   = (cnt == 2'd1) ? shm_pkg::SRC_W0 : shm_pkg::SRC_K;
            cnt_next   = 2'd0;
            state_next = S_QPRE;
          end else if (cnt[1] == 1'b0) begin
            cmd.early_wr  = 1'b1;
            cmd.early_idx = cnt[0];
            cnt_next      = cnt + 2'd1;
          end else begin
            src_next   = (cnt == 2'd2) ? shm_pkg::SRC_W0 : shm_pkg::SRC_K;
            cnt_next   = stat.is_last ? 2'd0 : 2'd3;
            lastf_next = stat.is_last;
            fullf_next = stat.is_full;
            state_next = S_SC1;
          end
        end
      end
      S_SC1: begin
        cmd.op     = shm_pkg::OP_SC1;
        state_next = S_SC2;
      end
      S_SC2: begin
        cmd.op     = shm_pkg::OP_SC2;
        state_next = S_MIX;
      end
      S_MIX: begin
        if (src == shm_pkg::SRC_K && lastf && !fullf) begin
          cmd.op     = shm_pkg::OP_TAIL;
          state_next = S_FM1;
        end else begin
          cmd.op = shm_pkg::OP_BODY;
          if (src == shm_pkg::SRC_W0) begin
            src_next   = shm_pkg::SRC_W1;
            state_next = S_SC1;
          end else if (src == shm_pkg::SRC_W1) begin
            src_next   = shm_pkg::SRC_K;
            state_next = S_SC1;
          end else begin
            state_next = lastf ? S_FM1 : S_IDLE;
          end
        end
      end
      S_FM1: begin
        cmd.op     = shm_pkg::OP_FMIX1;
        state_next = S_FM2;
      end
      S_FM2: begin
        cmd.op     = shm_pkg::OP_FMIX2;
        state_next = S_OUT;
      end
      S_QPRE: begin
        cmd.op     = shm_pkg::OP_QPRE;
        state_next = S_QMUL;
      end
      S_QMUL: begin
        cmd.op     = shm_pkg::OP_QMUL;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.op     = shm_pkg::OP_OUT;
          issue_out  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (issue_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= 2'd0;
      src       <= shm_pkg::SRC_K;
      lastf     <= 1'b0;
      fullf     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      src       <= src_next;
      lastf     <= lastf_next;
      fullf     <= fullf_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: rtl/core/shm_dp.sv
// ----------------------------------------------------------------------------
// shm_dp: datapath for the short-path string hash core
// Word capture, early-word hold, length tracking, one shared 32x32
// multiplier, and the result register.
// ----------------------------------------------------------------------------
module shm_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [31:0]          data_word,
  input  logic [2:0]           byte_count,
  input  logic                 last,
  input  shm_pkg::cmd_t        cmd,
  output shm_pkg::stat_t       stat,
  output logic [31:0]          hash_value
);

  logic [31:0] h, k, t, len, total, w0, w1;
  logic [2:0]  bce;
  logic [31:0] mask;
  logic [31:0] ma, mb;
  logic [31:0] prod;
  logic [31:0] fold_h, xl, fold_l, fold13, sc2_in, body_r, body_x;
  logic [31:0] src_word;
  logic [31:0] qa, q0, qx;
  logic [63:0] qbytes;
  logic [3:0]  qlen, qrem;
  logic [2:0]  qpos;

  assign bce = (byte_count == 3'd0 || byte_count > 3'd4) ? 3'd4 : byte_count;

  always_comb begin
    unique case (last ? bce : 3'd4)
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
  end

  assign stat.is_last = last;
  assign stat.is_full = (bce == 3'd4);

  always_comb begin
    unique case (cmd.src)
      shm_pkg::SRC_W0: src_word = w0;
      shm_pkg::SRC_W1: src_word = w1;
      default:         src_word = k;
    endcase
  end

  assign fold_h = h ^ {16'h0000, h[31:16]};
  assign xl     = h ^ len;
  assign fold_l = xl ^ {16'h0000, xl[31:16]};
  assign fold13 = h ^ {13'h0000, h[31:13]};
  assign sc2_in = {t[16:0], t[31:17]};
  assign body_x = h ^ t;
  assign body_r = {body_x[18:0], body_x[31:19]};

  // quick-path premix
  always_comb begin
    qa     = (cmd.src == shm_pkg::SRC_W0) ? w0 : k;
    qbytes = {k, qa};
    qlen   = len[3:0];
    q0     = shm_pkg::HASH_SEED ^ len;
    qpos   = 3'd0;
    qrem   = qlen;
    qx     = q0 ^ qa;
    if (qlen >= 4'd4) begin
      q0   = {qx[18:0], qx[31:19]};
      qpos = 3'd4;
      qrem = qlen - 4'd4;
    end
    if (qrem >= 4'd2) begin
      q0   = q0 ^ {16'h0000, qbytes[{qpos, 3'b000} +: 16]};
      qpos = qpos + 3'd2;
      qrem = qrem - 4'd2;
    end
    if (qrem >= 4'd1) begin
      q0 = q0 ^ {24'h000000, qbytes[{qpos, 3'b000} +: 8]};
    end
  end

  always_comb begin
    unique case (cmd.op)
      shm_pkg::OP_SC1: begin
        ma = src_word;
        mb = shm_pkg::MIX_C1;
      end
      shm_pkg::OP_SC2: begin
        ma = sc2_in;
        mb = shm_pkg::MIX_C2;
      end
      shm_pkg::OP_FMIX1: begin
        ma = fold_l;
        mb = shm_pkg::FIN_C1;
      end
      shm_pkg::OP_FMIX2: begin
        ma = fold13;
        mb = shm_pkg::FIN_C2;
      end
      default: begin
        ma = h;
        mb = shm_pkg::FIN_C1;
      end
    endcase
  end

  assign prod = ma * mb;

  always_ff @(posedge clk) begin
    if (rst) begin
      h     <= shm_pkg::HASH_SEED;
      total <= 32'd0;
    end else begin
      if (cmd.accept) begin
        if (last) begin
          total <= 32'd0;
        end else begin
          total <= total + 32'd4;
        end
      end
      unique case (cmd.op)
        shm_pkg::OP_BODY:  h <= {body_r[29:0], 2'b00} + body_r + shm_pkg::MIX_C3;
        shm_pkg::OP_TAIL:  h <= h ^ t;
        shm_pkg::OP_FMIX1: h <= prod[31:0];
        shm_pkg::OP_FMIX2: h <= prod[31:0];
        shm_pkg::OP_QPRE:  h <= q0;
        shm_pkg::OP_QMUL:  h <= prod[31:0];
        shm_pkg::OP_OUT:   h <= shm_pkg::HASH_SEED;
        default:           h <= h;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      k <= data_word & mask;
      if (last) begin
        len <= total + {29'd0, bce};
      end
    end
    if (cmd.early_wr) begin
      if (cmd.early_idx) begin
        w1 <= data_word;
      end else begin
        w0 <= data_word;
      end
    end
    if (cmd.op == shm_pkg::OP_SC1 || cmd.op == shm_pkg::OP_SC2) begin
      t <= prod[31:0];
    end
    if (cmd.op == shm_pkg::OP_OUT) begin
      hash_value <= (fold_h == 32'd0) ? 32'd1 : fold_h;
    end
  end

endmodule

FILE: rtl/core/string_hash_murmur_short_path_core.sv
// ----------------------------------------------------------------------------
// string_hash_murmur_short_path_core: streaming 32-bit string hash
// MurmurHash3 x86_32 style hash with a quick path for strings of 8 bytes or
// fewer; one word in per request, one hash out per string.
//
//   channel | signals                            | moves
//   --------+------------------------------------+------------------------
//   in      | in_valid, in_ready, data_word,     | one word of the string
//           | byte_count, last                   |
//   out     | out_valid, out_ready, hash_value   | hash of a whole string
//
// The first two words of a string are held in registers.
// Each later word goes through the shared multiplier (scramble x2,
// body); the third word also flushes the two held words.
// A last word adds finalizer steps (long path) or quick-path steps.
// Reset clears the sequencer and running state; a pending hash waits in the
// output register while the next string's early words are accepted.
// ----------------------------------------------------------------------------
module string_hash_murmur_short_path_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] hash_value
);

  shm_pkg::cmd_t  cmd;
  shm_pkg::stat_t stat;

  shm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  shm_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .data_word  (data_word),
    .byte_count (byte_count),
    .last       (last),
    .cmd        (cmd),
    .stat       (stat),
    .hash_value (hash_value)
  );

endmodule

FILE: test/string_hash_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_hash_checker: scoreboard for the short-path string hash core
// Watches both channels, keeps its own model of the string hash (quick path
// for strings of up to two words, long-path body and finalizer otherwise) and
// compares every hash leaving the core with the oldest predicted one.
// ----------------------------------------------------------------------------
module string_hash_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] hash_value,
  output int          mismatches,
  output int          pending
);

  localparam logic [31:0] SEED   = 32'h9747b28c;
  localparam logic [31:0] K_MIX1 = 32'hcc9e2d51;
  localparam logic [31:0] K_MIX2 = 32'h1b873593;
  localparam logic [31:0] K_MIX3 = 32'he6546b64;
  localparam logic [31:0] K_FIN1 = 32'h85ebca6b;
  localparam logic [31:0] K_FIN2 = 32'hc2b2ae35;

  logic [31:0] body_hash;
  logic [31:0] bytes_seen;
  logic [31:0] held_words [2];
  logic [1:0]  held_count;
  logic [31:0] pending_hashes [$];

  initial begin
    mismatches = 0;
    pending = 0;
  end

  function automatic logic [31:0] rotl(input logic [31:0] v, input int r);
    return (v << r) | (v >> (32 - r));
  endfunction

  function automatic logic [31:0] scramble(input logic [31:0] k);
    logic [31:0] t;
    t = k * K_MIX1;
    t = rotl(t, 15);
    return t * K_MIX2;
  endfunction

  function automatic logic [31:0] mix_block(input logic [31:0] h, input logic [31:0] k);
    logic [31:0] t;
    t = rotl(h ^ scramble(k), 13);
    return t * 32'd5 + K_MIX3;
  endfunction

  // short strings; byte 7 of an 8-byte string is never mixed in
  function automatic logic [31:0] short_hash(input logic [31:0] w0, input logic [31:0] w1,
                                             input logic [31:0] len);
    logic [63:0] str;
    logic [31:0] h;
    int          pos;
    logic [31:0] rem;
    str = {w1, w0};
    h = SEED ^ len;
    pos = 0;
    rem = len;
    if (rem >= 4) begin
      h = rotl(h ^ w0, 13);
      pos = 4;
      rem = rem - 4;
    end
    if (rem >= 2) begin
      h = h ^ {16'h0, str[8*pos +: 16]};
      pos = pos + 2;
      rem = rem - 2;
    end
    if (rem >= 1) begin
      h = h ^ {24'h0, str[8*pos +: 8]};
    end
    h = h * K_FIN1;
    return h ^ (h >> 16);
  endfunction

  function automatic logic [31:0] long_hash(input logic [31:0] h_in, input logic [31:0] w,
                                            input logic [2:0] bc, input logic [31:0] len);
    logic [31:0] h;
    logic [31:0] keep;
    h = h_in;
    if (bc == 3'd4) begin
      h = mix_block(h, w);
    end else begin
      keep = (32'd1 << (8 * bc)) - 32'd1;
      h = h ^ scramble(w & keep);
    end
    h = h ^ len;
    h = h ^ (h >> 16);
    h = h * K_FIN1;
    h = h ^ (h >> 13);
    h = h * K_FIN2;
    return h ^ (h >> 16);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("ERROR at %0t: %s: expected %08h, got %08h", $time, what, want, got);
    mismatches = mismatches + 1;
  endtask

  always @(posedge clk) begin : watch
    logic [2:0]  bc;
    logic [31:0] h;
    logic [31:0] want;
    if (rst) begin
      body_hash = SEED;
      bytes_seen = 32'd0;
      held_count = 2'd0;
      pending_hashes.delete();
    end else begin
      if (in_valid && in_ready) begin
        bc = (byte_count == 3'd0 || byte_count > 3'd4) ? 3'd4 : byte_count;
        if (last && held_count < 2'd2) begin
          if (held_count == 2'd0)
            h = short_hash(data_word, 32'd0, {29'd0, bc});
          else
            h = short_hash(held_words[0], data_word, 32'd4 + bc);
          pending_hashes = {pending_hashes, ((h == 32'd0) ? 32'd1 : h)};
          body_hash = SEED;
          bytes_seen = 32'd0;
          held_count = 2'd0;
        end else if (held_count < 2'd2) begin
          held_words[held_count[0]] = data_word;
          held_count = held_count + 2'd1;
          bytes_seen = bytes_seen + 32'd4;
        end else begin
          // third and later words; the third word first flushes the two held words into the body
          if (held_count == 2'd2) begin
            body_hash = mix_block(body_hash, held_words[0]);
            body_hash = mix_block(body_hash, held_words[1]);
            held_count = 2'd3;
          end
          if (!last) begin
            body_hash = mix_block(body_hash, data_word);
            bytes_seen = bytes_seen + 32'd4;
          end else begin
            h = long_hash(body_hash, data_word, bc, bytes_seen + bc);
            pending_hashes = {pending_hashes, ((h == 32'd0) ? 32'd1 : h)};
            body_hash = SEED;
            bytes_seen = 32'd0;
            held_count = 2'd0;
          end
        end
      end
      if (out_valid && out_ready) begin
        if (pending_hashes.size() == 0) begin
          report_mismatch("hash with no string pending", 32'd0, hash_value);
        end else begin
          want = pending_hashes.pop_front();
          if (hash_value !== want)
            report_mismatch("hash_value", want, hash_value);
        end
      end
    end
    pending <= pending_hashes.size();
  end

endmodule

FILE: test/tb_string_hash_murmur_short_path_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_string_hash_murmur_short_path_core: testbench for the string hash core
// Sends directed strings (every length class, odd byte counts, stray bytes)
// and then random strings of one to sixteen words in bursts with gaps, while
// the hash side stalls on its own pattern; a checker predicts every hash.
// ----------------------------------------------------------------------------
module tb_string_hash_murmur_short_path_core;

  localparam int CYCLE_LIMIT = 400000;
  localparam int WORD_TARGET = 1850;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] data_word = 32'd0;
  logic [2:0]  byte_count = 3'd4;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] hash_value;

  int mismatches;
  int pending;
  int cycle_count = 0;
  int words_sent = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;

  string_hash_murmur_short_path_core uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_word  (data_word),
    .byte_count (byte_count),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash_value (hash_value)
  );

  string_hash_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_word  (data_word),
    .byte_count (byte_count),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash_value (hash_value),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // hash side: always ready, random, or mostly stalled
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  task automatic send_word(input logic [31:0] w, input logic [2:0] bc, input logic fin);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    data_word <= w;
    byte_count <= bc;
    last <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left = burst_left - 1;
    words_sent = words_sent + 1;
  endtask

  initial begin : stimulus
    int          nwords;
    int          sel;
    logic [31:0] w;
    logic [2:0]  bc;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-word strings, all byte counts, stray bytes, out-of-range count
    send_word(32'h00000000, 3'd1, 1'b1);
    send_word(32'hffffffff, 3'd1, 1'b1);
    send_word(32'h12345678, 3'd2, 1'b1);
    send_word(32'ha5a5a5a5, 3'd3, 1'b1);
    send_word(32'hffffffff, 3'd4, 1'b1);
    send_word(32'hdeadbeef, 3'd0, 1'b1);
    // two-word strings: 8 bytes, short count on a non-last word
    send_word(32'hffffffff, 3'd4, 1'b0);
    send_word(32'hffffffff, 3'd4, 1'b1);
    send_word(32'h87654321, 3'd1, 1'b0);
    send_word(32'h0f1e2d3c, 3'd7, 1'b1);
    // long strings
    send_word(32'h01020304, 3'd4, 1'b0);
    send_word(32'h05060708, 3'd4, 1'b0);
    send_word(32'hcafef00d, 3'd1, 1'b1);
    send_word(32'h11111111, 3'd2, 1'b0);
    send_word(32'h22222222, 3'd4, 1'b0);
    send_word(32'h33333333, 3'd4, 1'b0);
    send_word(32'h44444444, 3'd5, 1'b1);
    send_word(32'h00000000, 3'd4, 1'b0);
    send_word(32'h00000000, 3'd4, 1'b0);
    send_word(32'h00000000, 3'd6, 1'b1);
    send_word(32'hffffffff, 3'd4, 1'b0);
    send_word(32'hffffffff, 3'd4, 1'b0);
    send_word(32'hffffffff, 3'd3, 1'b1);

    while (words_sent < WORD_TARGET) begin
      sel = $urandom_range(0, 99);
      if (sel < 40)
        nwords = $urandom_range(1, 2);
      else if (sel < 90)
        nwords = $urandom_range(3, 6);
      else
        nwords = $urandom_range(7, 16);
      for (int i = 0; i < nwords; i++) begin
        case ($urandom_range(0, 9))
          0: w = 32'h00000000;
          1: w = 32'hffffffff;
          default: w = $urandom;
        endcase
        if ($urandom_range(0, 9) == 0)
          bc = 3'($urandom_range(0, 7));
        else if (i == nwords - 1)
          bc = 3'($urandom_range(1, 4));
        else
          bc = 3'd4;
        send_word(w, bc, (i == nwords - 1));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/shm_pkg.sv
rtl/core/shm_ctrl.sv
rtl/core/shm_dp.sv
rtl/core/string_hash_murmur_short_path_core.sv
test/string_hash_checker.sv
test/tb_string_hash_murmur_short_path_core.sv
